// File: rtl/hsvled_pkg.sv
package hsvled_pkg;

    // Opcodes of the command channel
    localparam logic [2:0] OP_SET_HUE   = 3'd0;
    localparam logic [2:0] OP_SET_BRI   = 3'd1;
    localparam logic [2:0] OP_ADJ_HUE   = 3'd2;
    localparam logic [2:0] OP_ADJ_BRI   = 3'd3;
    localparam logic [2:0] OP_SEG_START = 3'd4;
    localparam logic [2:0] OP_SEG_END   = 3'd5;
    localparam logic [2:0] OP_MOTION    = 3'd6;
    localparam logic [2:0] OP_PIXEL     = 3'd7;

    // Window registers hold any LED position of the largest strip
    localparam int WIN_W = 10;

    // Shared multiplier operand and product widths
    localparam int MUL_A_W = 24;
    localparam int MUL_B_W = 28;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_HUE_MUL,
        ST_HUE_WR,
        ST_PCT_MUL,
        ST_PCT_WR,
        ST_ADJ,
        ST_SEG,
        ST_MOT_P,
        ST_MOT_R,
        ST_MOT_Y,
        ST_MOT_H,
        ST_MOT_S,
        ST_MOT_B,
        ST_COL_HV,
        ST_COL_VS,
        ST_COL_CT,
        ST_COL_X,
        ST_COL_OUT
    } state_t;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_HUE,
        MUL_PCT,
        MUL_PITCH,
        MUL_ROLL,
        MUL_YAW,
        MUL_SAT,
        MUL_BRI,
        MUL_VS,
        MUL_CT,
        MUL_X15
    } mul_sel_t;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_HUE_WR,
        ACT_PCT_WR,
        ACT_BRI_ADJ,
        ACT_SEG,
        ACT_NP,
        ACT_NR,
        ACT_NY_HUE,
        ACT_SAT,
        ACT_MOT_BRI,
        ACT_HV,
        ACT_T,
        ACT_C,
        ACT_OUT
    } act_t;

    typedef struct packed {
        logic     load;
        mul_sel_t mul_sel;
        act_t     act;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_stat_t;

endpackage

// File: rtl/hsvled_ctrl.sv
module hsvled_ctrl import hsvled_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_opcode,
    input  dp_stat_t   stat,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_opcode inside {OP_SET_HUE, OP_ADJ_HUE}) begin
                        state_next = ST_HUE_MUL;
                    end else if (s_opcode == OP_SET_BRI) begin
                        state_next = ST_PCT_MUL;
                    end else if (s_opcode == OP_ADJ_BRI) begin
                        state_next = ST_ADJ;
                    end else if (s_opcode inside {OP_SEG_START, OP_SEG_END}) begin
                        state_next = ST_SEG;
                    end else if (s_opcode == OP_MOTION) begin
                        state_next = ST_MOT_P;
                    end else begin
                        state_next = ST_COL_HV;
                    end
                end
            end
            ST_HUE_MUL: state_next = ST_HUE_WR;
            ST_HUE_WR:  state_next = ST_COL_HV;
            ST_PCT_MUL: state_next = ST_PCT_WR;
            ST_PCT_WR:  state_next = ST_COL_HV;
            ST_ADJ:     state_next = ST_COL_HV;
            ST_SEG:     state_next = ST_COL_HV;
            ST_MOT_P:   state_next = ST_MOT_R;
            ST_MOT_R:   state_next = ST_MOT_Y;
            ST_MOT_Y:   state_next = ST_MOT_H;
            ST_MOT_H:   state_next = ST_MOT_S;
            ST_MOT_S:   state_next = ST_MOT_B;
            ST_MOT_B:   state_next = ST_COL_HV;
            ST_COL_HV:  state_next = ST_COL_VS;
            ST_COL_VS:  state_next = ST_COL_CT;
            ST_COL_CT:  state_next = ST_COL_X;
            ST_COL_X:   state_next = ST_COL_OUT;
            ST_COL_OUT: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready     = 1'b0;
        cmd.load    = 1'b0;
        cmd.mul_sel = MUL_NONE;
        cmd.act     = ACT_NONE;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_HUE_MUL: cmd.mul_sel = MUL_HUE;
            ST_HUE_WR:  cmd.act = ACT_HUE_WR;
            ST_PCT_MUL: cmd.mul_sel = MUL_PCT;
            ST_PCT_WR:  cmd.act = ACT_PCT_WR;
            ST_ADJ:     cmd.act = ACT_BRI_ADJ;
            ST_SEG:     cmd.act = ACT_SEG;
            ST_MOT_P:   cmd.mul_sel = MUL_PITCH;
            ST_MOT_R: begin
                cmd.act     = ACT_NP;
                cmd.mul_sel = MUL_ROLL;
            end
            ST_MOT_Y: begin
                cmd.act     = ACT_NR;
                cmd.mul_sel = MUL_YAW;
            end
            ST_MOT_H: begin
                cmd.act     = ACT_NY_HUE;
                cmd.mul_sel = MUL_SAT;
            end
            ST_MOT_S: begin
                cmd.act     = ACT_SAT;
                cmd.mul_sel = MUL_BRI;
            end
            ST_MOT_B:   cmd.act = ACT_MOT_BRI;
            ST_COL_HV:  cmd.act = ACT_HV;
            ST_COL_VS: begin
                cmd.act     = ACT_T;
                cmd.mul_sel = MUL_VS;
            end
            ST_COL_CT: begin
                cmd.act     = ACT_C;
                cmd.mul_sel = MUL_CT;
            end
            ST_COL_X:   cmd.mul_sel = MUL_X15;
            ST_COL_OUT: begin
                if (stat.out_free) begin
                    cmd.act = ACT_OUT;
                end
            end
            default: begin
                cmd.act = ACT_NONE;
            end
        endcase
    end

endmodule

// File: rtl/hsvled_dp.sv
module hsvled_dp import hsvled_pkg::*; #(
    parameter int LED_COUNT = 300
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata,
    input  logic [2:0]         s_opcode,
    input  logic signed [31:0] s_value,
    input  logic [15:0]        s_segment_number,
    input  logic [9:0]         s_pixel_index,
    input  logic signed [15:0] s_pitch_angle,
    input  logic signed [15:0] s_roll_angle,
    input  logic signed [15:0] s_yaw_angle,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [23:0]        m_grb_color,
    output logic [23:0]        m_pixel_color,
    output logic [8:0]         m_first_lit,
    output logic [8:0]         m_last_lit,
    input  dp_cmd_t            cmd,
    output dp_stat_t           stat
);

    localparam logic [WIN_W-1:0] LAST_LED = WIN_W'(LED_COUNT - 1);
    localparam logic [15:0] ONE_Q15    = 16'd32768;
    localparam logic [15:0] TURN_Q7    = 16'd46080;
    localparam logic [15:0] SECTOR_Q7  = 16'd7680;
    localparam logic [23:0] HUE_BIAS   = 24'd4239360;
    localparam logic [16:0] HUE_RECIP  = 17'd93206;
    localparam logic [19:0] PCT_RECIP  = 20'd671089;
    localparam logic signed [31:0] PCT_LIMIT = 32'sd6553600;
    localparam logic [27:0] ANG_RECIP  = 28'd170890835;
    localparam logic signed [16:0] HALF_PI_Q12 = 17'sd6434;
    localparam logic signed [16:0] PI_Q12      = 17'sd12868;
    localparam logic signed [16:0] TWO_PI_Q12  = 17'sd25736;
    localparam logic [17:0] FIFTH_RECIP     = 18'd209716;
    localparam logic [20:0] FIFTEENTH_RECIP = 21'd1118482;
    localparam logic [15:0] SAT_BASE   = 16'd11469;
    localparam logic [15:0] BRI_BASE   = 16'd6554;

    function automatic logic [7:0] to_byte(input logic [16:0] q);
        logic [25:0] p;
        p = 26'(q) * 26'd255;
        to_byte = (p[25:15] > 11'd255) ? 8'hFF : p[22:15];
    endfunction

    // Architectural state
    logic [15:0]        min_br_reg;
    logic [15:0]        base_hue_reg, base_hue_next;
    logic [15:0]        base_sat_reg, base_sat_next;
    logic [15:0]        base_bri_reg, base_bri_next;
    logic [15:0]        hue_shift_reg, hue_shift_next;
    logic signed [16:0] bri_shift_reg, bri_shift_next;
    logic [WIN_W-1:0]   ws_reg, ws_next;
    logic [WIN_W-1:0]   we_reg, we_next;

    // Latched request
    logic [2:0]         op_reg;
    logic signed [31:0] val_reg;
    logic [15:0]        segn_reg;
    logic [9:0]         pix_reg;
    logic signed [15:0] pitch_reg, roll_reg, yaw_reg;

    // Working registers
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [15:0]        np_reg, np_next;
    logic [15:0]        nr_reg, nr_next;
    logic [15:0]        h_reg, h_next;
    logic [15:0]        v_reg, v_next;
    logic [12:0]        t_reg, t_next;
    logic [2:0]         sector_reg, sector_next;
    logic [15:0]        c_reg;

    // Result register
    logic               m_valid_reg;
    logic [23:0]        grb_reg, grb_next;
    logic [23:0]        pixc_reg, pixc_next;
    logic [8:0]         first_reg, last_reg;

    logic [15:0]        floor_lvl;
    logic [23:0]        hue_y;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic signed [16:0] pitch_a, roll_b, yaw_b;
    logic [18:0]        sat_13;
    logic [23:0]        hue_qm, hue_r0, hue_r1;
    logic [15:0]        pct_q;
    logic signed [32:0] adj_sum;
    logic [15:0]        adj_level;
    logic [15:0]        seg_m1;
    logic [WIN_W-1:0]   seg_idx;
    logic [15:0]        ny_val;
    logic [23:0]        mot_sum;
    logic [15:0]        mot_hh;
    logic [15:0]        mot_bri;
    logic [16:0]        h_sum;
    logic signed [17:0] v_sum;
    logic [15:0]        sec_base, frac;
    logic [15:0]        x_val, m_val;
    logic [16:0]        ch_r, ch_g, ch_b;

    assign floor_lvl = (min_br_reg > ONE_Q15) ? ONE_Q15 : min_br_reg;

    // Hue in Q17.7, biased positive so the reciprocal multiply sees an unsigned value
    assign hue_y = {val_reg[31], val_reg[31:9]} + HUE_BIAS
                 + ((op_reg == OP_ADJ_HUE) ? {8'd0, hue_shift_reg} : 24'd0);

    assign pitch_a = $signed({pitch_reg[15], pitch_reg}) + HALF_PI_Q12;
    assign roll_b  = $signed({roll_reg[15], roll_reg}) + PI_Q12;
    assign yaw_b   = $signed({yaw_reg[15], yaw_reg}) + PI_Q12;
    assign sat_13  = 19'(nr_reg) * 19'd13;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_sel)
            MUL_HUE: begin
                mul_a = hue_y;
                mul_b = MUL_B_W'(HUE_RECIP);
            end
            MUL_PCT: begin
                mul_a = MUL_A_W'(val_reg[22:3]);
                mul_b = MUL_B_W'(PCT_RECIP);
            end
            MUL_PITCH: begin
                mul_a = MUL_A_W'(pitch_a[13:0]);
                mul_b = ANG_RECIP;
            end
            MUL_ROLL: begin
                mul_a = MUL_A_W'(roll_b[14:0]);
                mul_b = ANG_RECIP;
            end
            MUL_YAW: begin
                mul_a = MUL_A_W'(yaw_b[14:0]);
                mul_b = ANG_RECIP;
            end
            MUL_SAT: begin
                mul_a = MUL_A_W'(sat_13[18:2]);
                mul_b = MUL_B_W'(FIFTH_RECIP);
            end
            MUL_BRI: begin
                mul_a = MUL_A_W'({np_reg, 2'b00});
                mul_b = MUL_B_W'(FIFTH_RECIP);
            end
            MUL_VS: begin
                mul_a = MUL_A_W'(v_reg);
                mul_b = MUL_B_W'(base_sat_reg);
            end
            MUL_CT: begin
                mul_a = MUL_A_W'(prod_reg[30:15]);
                mul_b = MUL_B_W'(t_reg);
            end
            MUL_X15: begin
                mul_a = MUL_A_W'(prod_reg[27:9]);
                mul_b = MUL_B_W'(FIFTEENTH_RECIP);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // Remainder after the reciprocal quotient; the quotient may be one short
    assign hue_qm = 24'(prod_reg[39:32]) * 24'(TURN_Q7);
    assign hue_r0 = hue_y - hue_qm;
    assign hue_r1 = (hue_r0 >= 24'(TURN_Q7)) ? hue_r0 - 24'(TURN_Q7) : hue_r0;

    assign pct_q = prod_reg[39:24];

    assign adj_sum = $signed({17'd0, base_bri_reg})
                   + $signed({{16{bri_shift_reg[16]}}, bri_shift_reg})
                   + $signed({{2{val_reg[31]}}, val_reg[31:1]});

    always_comb begin
        if (adj_sum < $signed({17'd0, floor_lvl})) begin
            adj_level = floor_lvl;
        end else if (adj_sum > $signed({17'd0, ONE_Q15})) begin
            adj_level = ONE_Q15;
        end else begin
            adj_level = adj_sum[15:0];
        end
    end

    assign seg_m1  = (segn_reg == 16'd0) ? 16'd0 : segn_reg - 16'd1;
    assign seg_idx = (seg_m1 >= 16'(LED_COUNT)) ? LAST_LED : seg_m1[WIN_W-1:0];

    assign ny_val  = (yaw_b < 0) ? 16'd0 :
                     (yaw_b >= TWO_PI_Q12) ? ONE_Q15 : prod_reg[42:27];
    assign mot_sum = 24'(ny_val) * 24'd360 + 24'(nr_reg) * 24'd120;
    assign mot_hh  = mot_sum[23:8];
    assign mot_bri = BRI_BASE + prod_reg[35:20];

    assign h_sum = 17'(base_hue_reg) + 17'(hue_shift_reg);
    assign v_sum = $signed({2'b00, base_bri_reg})
                 + $signed({bri_shift_reg[16], bri_shift_reg});

    always_comb begin
        base_hue_next  = base_hue_reg;
        base_sat_next  = base_sat_reg;
        base_bri_next  = base_bri_reg;
        hue_shift_next = hue_shift_reg;
        bri_shift_next = bri_shift_reg;
        ws_next        = ws_reg;
        we_next        = we_reg;
        np_next        = np_reg;
        nr_next        = nr_reg;
        case (cmd.act)
            ACT_HUE_WR: begin
                if (op_reg == OP_ADJ_HUE) begin
                    hue_shift_next = hue_r1[15:0];
                end else begin
                    base_hue_next  = hue_r1[15:0];
                    hue_shift_next = 16'd0;
                end
            end
            ACT_PCT_WR: begin
                if (val_reg[31]) begin
                    base_bri_next = floor_lvl;
                end else if (val_reg >= PCT_LIMIT) begin
                    base_bri_next = ONE_Q15;
                end else begin
                    base_bri_next = (pct_q < floor_lvl) ? floor_lvl : pct_q;
                end
                bri_shift_next = 17'sd0;
            end
            ACT_BRI_ADJ: begin
                bri_shift_next = $signed({1'b0, adj_level}) - $signed({1'b0, base_bri_reg});
            end
            ACT_SEG: begin
                if (op_reg == OP_SEG_START) begin
                    ws_next = seg_idx;
                    we_next = (seg_idx > we_reg) ? seg_idx : we_reg;
                end else begin
                    we_next = (seg_idx < ws_reg) ? ws_reg : seg_idx;
                end
            end
            ACT_NP: begin
                np_next = (pitch_a < 0) ? 16'd0 :
                          (pitch_a >= PI_Q12) ? ONE_Q15 : prod_reg[41:26];
            end
            ACT_NR: begin
                nr_next = (roll_b < 0) ? 16'd0 :
                          (roll_b >= TWO_PI_Q12) ? ONE_Q15 : prod_reg[42:27];
            end
            ACT_NY_HUE: begin
                base_hue_next = (mot_hh >= TURN_Q7) ? mot_hh - TURN_Q7 : mot_hh;
            end
            ACT_SAT: begin
                base_sat_next = SAT_BASE + prod_reg[35:20];
            end
            ACT_MOT_BRI: begin
                base_bri_next = (mot_bri < floor_lvl) ? floor_lvl : mot_bri;
            end
            default: begin
                base_hue_next = base_hue_reg;
            end
        endcase
    end

    always_comb begin
        h_next = (h_sum >= 17'(TURN_Q7)) ? 16'(h_sum - 17'(TURN_Q7)) : h_sum[15:0];
        if (v_sum < $signed({2'b00, floor_lvl})) begin
            v_next = floor_lvl;
        end else if (v_sum > $signed({2'b00, ONE_Q15})) begin
            v_next = ONE_Q15;
        end else begin
            v_next = v_sum[15:0];
        end
    end

    always_comb begin
        if (h_reg >= 16'd38400) begin
            sector_next = 3'd5;
        end else if (h_reg >= 16'd30720) begin
            sector_next = 3'd4;
        end else if (h_reg >= 16'd23040) begin
            sector_next = 3'd3;
        end else if (h_reg >= 16'd15360) begin
            sector_next = 3'd2;
        end else if (h_reg >= SECTOR_Q7) begin
            sector_next = 3'd1;
        end else begin
            sector_next = 3'd0;
        end
        sec_base = 16'(sector_next) * SECTOR_Q7;
        frac     = h_reg - sec_base;
        t_next   = sector_next[0] ? 13'(SECTOR_Q7 - frac) : frac[12:0];
    end

    assign x_val = prod_reg[39:24];
    assign m_val = v_reg - c_reg;

    always_comb begin
        ch_r = 17'(m_val);
        ch_g = 17'(m_val);
        ch_b = 17'(m_val);
        case (sector_reg)
            3'd0: begin
                ch_r = 17'(m_val) + 17'(c_reg);
                ch_g = 17'(m_val) + 17'(x_val);
            end
            3'd1: begin
                ch_r = 17'(m_val) + 17'(x_val);
                ch_g = 17'(m_val) + 17'(c_reg);
            end
            3'd2: begin
                ch_g = 17'(m_val) + 17'(c_reg);
                ch_b = 17'(m_val) + 17'(x_val);
            end
            3'd3: begin
                ch_g = 17'(m_val) + 17'(x_val);
                ch_b = 17'(m_val) + 17'(c_reg);
            end
            3'd4: begin
                ch_r = 17'(m_val) + 17'(x_val);
                ch_b = 17'(m_val) + 17'(c_reg);
            end
            default: begin
                ch_r = 17'(m_val) + 17'(c_reg);
                ch_b = 17'(m_val) + 17'(x_val);
            end
        endcase
        grb_next  = {to_byte(ch_g), to_byte(ch_r), to_byte(ch_b)};
        pixc_next = ((op_reg == OP_PIXEL) && (pix_reg >= ws_reg) && (pix_reg <= we_reg))
                  ? grb_next : 24'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_br_reg    <= 16'd1638;
            base_hue_reg  <= 16'd3200;
            base_sat_reg  <= ONE_Q15;
            base_bri_reg  <= 16'd16062;
            hue_shift_reg <= 16'd0;
            bri_shift_reg <= 17'sd0;
            ws_reg        <= '0;
            we_reg        <= LAST_LED;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                min_br_reg <= cfg_wdata;
            end
            base_hue_reg  <= base_hue_next;
            base_sat_reg  <= base_sat_next;
            base_bri_reg  <= base_bri_next;
            hue_shift_reg <= hue_shift_next;
            bri_shift_reg <= bri_shift_next;
            ws_reg        <= ws_next;
            we_reg        <= we_next;
            if (cmd.act == ACT_OUT) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= s_opcode;
            val_reg   <= s_value;
            segn_reg  <= s_segment_number;
            pix_reg   <= s_pixel_index;
            pitch_reg <= s_pitch_angle;
            roll_reg  <= s_roll_angle;
            yaw_reg   <= s_yaw_angle;
        end
        if (cmd.mul_sel != MUL_NONE) begin
            prod_reg <= prod_next;
        end
        np_reg <= np_next;
        nr_reg <= nr_next;
        if (cmd.act == ACT_HV) begin
            h_reg <= h_next;
            v_reg <= v_next;
        end
        if (cmd.act == ACT_T) begin
            sector_reg <= sector_next;
            t_reg      <= t_next;
        end
        if (cmd.act == ACT_C) begin
            c_reg <= prod_reg[30:15];
        end
        if (cmd.act == ACT_OUT) begin
            grb_reg   <= grb_next;
            pixc_reg  <= pixc_next;
            first_reg <= ws_reg[8:0];
            last_reg  <= we_reg[8:0];
        end
    end

    assign stat.out_free = !m_valid_reg || m_ready;
    assign m_valid       = m_valid_reg;
    assign m_grb_color   = grb_reg;
    assign m_pixel_color = pixc_reg;
    assign m_first_lit   = first_reg;
    assign m_last_lit    = last_reg;

`ifndef SYNTHESIS
    a_window_order: assert property (@(posedge aclk) disable iff (!aresetn)
        ws_reg <= we_reg)
        else $error("segment start beyond segment end");

    a_window_range: assert property (@(posedge aclk) disable iff (!aresetn)
        we_reg <= LAST_LED)
        else $error("segment end beyond strip");

    a_hue_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (base_hue_reg < TURN_Q7) && (hue_shift_reg < TURN_Q7))
        else $error("hue not wrapped");

    a_pixel_color: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (pixc_reg != 24'd0)) |-> (pixc_reg == grb_reg))
        else $error("pixel color differs from current color");
`endif

endmodule

// File: rtl/hsv_led_strip_color_controller_top.sv
// Channel   | Handshake              | Payload
// ----------+------------------------+-------------------------------------------------
// command   | s_valid / s_ready      | s_opcode, s_value, s_segment_number,
//           |                        | s_pixel_index, s_pitch_angle, s_roll_angle,
//           |                        | s_yaw_angle
// result    | m_valid / m_ready      | m_grb_color, m_pixel_color, m_first_lit, m_last_lit
// config    | cfg_we                 | cfg_wdata (brightness floor, Q1.15)
//
// A request occupies the block from its accept cycle until its result enters the output
// register; s_ready is high only while idle. Every request ends with the HSV to GRB conversion
// (COL_HV, COL_VS, COL_CT, COL_X, COL_OUT) after its own update steps. One shared multiplier,
// used once per cycle, sets how long each request takes.
// aresetn is synchronous and active low; it restores the default color, clears the
// offsets and opens the window over the whole strip.
// A finished result sits in the output register until taken; the next request is
// accepted meanwhile and only its final cycle waits for the output register to free.
module hsv_led_strip_color_controller_top import hsvled_pkg::*; #(
    parameter int LED_COUNT = 300
) (
    input  logic               aclk,
    input  logic               aresetn,
    // brightness floor register
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata,
    // command channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_opcode,
    input  logic signed [31:0] s_value,
    input  logic [15:0]        s_segment_number,
    input  logic [9:0]         s_pixel_index,
    input  logic signed [15:0] s_pitch_angle,
    input  logic signed [15:0] s_roll_angle,
    input  logic signed [15:0] s_yaw_angle,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic [23:0]        m_grb_color,
    output logic [23:0]        m_pixel_color,
    output logic [8:0]         m_first_lit,
    output logic [8:0]         m_last_lit
);

    // Controller steps the datapath through the command update and the color
    // conversion; the datapath reports back whether the output register is free.
    dp_cmd_t  cmd;
    dp_stat_t stat;

    hsvled_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_opcode (s_opcode),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath holds the color state, the segment window, the shared multiplier
    // and the result register.
    hsvled_dp #(
        .LED_COUNT (LED_COUNT)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .s_opcode         (s_opcode),
        .s_value          (s_value),
        .s_segment_number (s_segment_number),
        .s_pixel_index    (s_pixel_index),
        .s_pitch_angle    (s_pitch_angle),
        .s_roll_angle     (s_roll_angle),
        .s_yaw_angle      (s_yaw_angle),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_grb_color      (m_grb_color),
        .m_pixel_color    (m_pixel_color),
        .m_first_lit      (m_first_lit),
        .m_last_lit       (m_last_lit),
        .cmd              (cmd),
        .stat             (stat)
    );

endmodule
